FILE: design/cln_pkg.sv
// Types, codes and control store for the character LCD nibble sequencer.
`default_nettype none
package cln_pkg;

  localparam int MAX_LINES = 4;
  localparam int NUM_BASES = 4;
  localparam int LINE_CNT  = (MAX_LINES < NUM_BASES) ? MAX_LINES : NUM_BASES;

  localparam int PC_W  = 5;
  localparam int IDX_W = 4;
  localparam int CFG_W = 16;

  localparam logic [2:0] CMD_DATA   = 3'd0;
  localparam logic [2:0] CMD_CMD    = 3'd1;
  localparam logic [2:0] CMD_INIT   = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_CURSOR = 3'd4;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_TEST     = 2'd1;
  localparam logic [1:0] STAT_BAD_LINE = 2'd2;
  localparam logic [1:0] STAT_UNSUP    = 2'd3;

  localparam logic [IDX_W-1:0] REG_TEST_MODE   = 4'd0;
  localparam logic [IDX_W-1:0] REG_LINE_BASE_0 = 4'd1;
  localparam logic [IDX_W-1:0] REG_LINE_BASE_1 = 4'd2;
  localparam logic [IDX_W-1:0] REG_LINE_BASE_2 = 4'd3;
  localparam logic [IDX_W-1:0] REG_LINE_BASE_3 = 4'd4;
  localparam logic [IDX_W-1:0] REG_SHORT_WAIT  = 4'd5;
  localparam logic [IDX_W-1:0] REG_LONG_WAIT   = 4'd6;
  localparam logic [IDX_W-1:0] REG_PULSE       = 4'd7;

  localparam logic [7:0] BYTE_CLEAR  = 8'h01;
  localparam logic [7:0] CURSOR_FLAG = 8'h80;
  localparam logic [7:0] SHORT_MASK  = 8'hfc;

  localparam logic [PC_W-1:0] ST_ERR  = 5'd0;
  localparam logic [PC_W-1:0] ST_BYTE = 5'd1;
  localparam logic [PC_W-1:0] ST_INIT = 5'd3;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] byte_value;
    logic [7:0] init_mode;
    logic [6:0] column;
    logic [2:0] line;
  } cln_in_t;

  typedef struct packed {
    logic        strobe_valid;
    logic        reg_select;
    logic [3:0]  nibble;
    logic [7:0]  enable_us;
    logic [15:0] wait_us;
    logic [1:0]  status;
    logic        last;
  } cln_out_t;

  typedef enum logic [1:0] {
    NIB_CONST,
    NIB_HI,
    NIB_LO
  } nib_sel_t;

  typedef enum logic [1:0] {
    WAIT_SHORT,
    WAIT_LONG,
    WAIT_LONG_IF_SMALL
  } wait_sel_t;

  typedef struct packed {
    logic      err;
    nib_sel_t  nib_sel;
    logic [3:0] nib;
    logic      rs_from_reg;
    wait_sel_t wait_sel;
    logic      last;
  } cln_uop_t;

  function automatic cln_uop_t cln_uop(logic err, nib_sel_t sel, logic [3:0] nib,
                                       logic rs, wait_sel_t ws, logic last);
    cln_uop_t u;
    u.err         = err;
    u.nib_sel     = sel;
    u.nib         = nib;
    u.rs_from_reg = rs;
    u.wait_sel    = ws;
    u.last        = last;
    return u;
  endfunction

  function automatic cln_uop_t cln_rom(logic [PC_W-1:0] pc);
    cln_uop_t u;
    unique case (pc)
      5'd0:    u = cln_uop(1'b1, NIB_CONST, 4'h0, 1'b0, WAIT_SHORT, 1'b1);
      5'd1:    u = cln_uop(1'b0, NIB_HI, 4'h0, 1'b1, WAIT_SHORT, 1'b0);
      5'd2:    u = cln_uop(1'b0, NIB_LO, 4'h0, 1'b1, WAIT_LONG_IF_SMALL, 1'b1);
      5'd3:    u = cln_uop(1'b0, NIB_CONST, 4'h3, 1'b0, WAIT_LONG, 1'b0);
      5'd4:    u = cln_uop(1'b0, NIB_CONST, 4'h3, 1'b0, WAIT_SHORT, 1'b0);
      5'd5:    u = cln_uop(1'b0, NIB_CONST, 4'h3, 1'b0, WAIT_SHORT, 1'b0);
      5'd6:    u = cln_uop(1'b0, NIB_CONST, 4'h2, 1'b0, WAIT_SHORT, 1'b0);
      5'd7:    u = cln_uop(1'b0, NIB_CONST, 4'h2, 1'b0, WAIT_SHORT, 1'b0);
      5'd8:    u = cln_uop(1'b0, NIB_CONST, 4'h8, 1'b0, WAIT_SHORT, 1'b0);
      5'd9:    u = cln_uop(1'b0, NIB_CONST, 4'h0, 1'b0, WAIT_SHORT, 1'b0);
      5'd10:   u = cln_uop(1'b0, NIB_CONST, 4'h8, 1'b0, WAIT_SHORT, 1'b0);
      5'd11:   u = cln_uop(1'b0, NIB_CONST, 4'h0, 1'b0, WAIT_SHORT, 1'b0);
      5'd12:   u = cln_uop(1'b0, NIB_CONST, 4'hc, 1'b0, WAIT_SHORT, 1'b0);
      5'd13:   u = cln_uop(1'b0, NIB_CONST, 4'h0, 1'b0, WAIT_SHORT, 1'b0);
      5'd14:   u = cln_uop(1'b0, NIB_CONST, 4'h6, 1'b0, WAIT_SHORT, 1'b0);
      5'd15:   u = cln_uop(1'b0, NIB_CONST, 4'h0, 1'b0, WAIT_SHORT, 1'b0);
      5'd16:   u = cln_uop(1'b0, NIB_CONST, 4'h1, 1'b0, WAIT_LONG, 1'b1);
      default: u = cln_uop(1'b1, NIB_CONST, 4'h0, 1'b0, WAIT_SHORT, 1'b1);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

FILE: design/char_lcd_nibble_sequencer.sv
// Top level: request dispatch, microcoded strobe sequencer and result register.
// The first result of a request is issued once busy is set and the output is not stalled.
// Throughput: one result per cycle while the output is not stalled; a request emits 1, 2
// or 14 results, and the next request is accepted the cycle after its last result is issued.
// The step counter walks the control store one word per issued result.
// Reset: synchronous, active low; clears control state and loads register defaults.
`default_nettype none
module char_lcd_nibble_sequencer import cln_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire cln_in_t          in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output cln_out_t              out_item,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  logic             test_mode_r, test_mode_nxt;
  logic [6:0]       line_base_r [NUM_BASES];
  logic [6:0]       line_base_nxt [NUM_BASES];
  logic [15:0]      short_wait_r, short_wait_nxt;
  logic [15:0]      long_wait_r, long_wait_nxt;
  logic [7:0]       pulse_r, pulse_nxt;

  logic             busy_r, busy_nxt;
  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             rs_r, rs_nxt;
  logic [1:0]       err_r, err_nxt;
  logic             out_valid_r, out_valid_nxt;
  cln_out_t         out_data_r, out_data_nxt;

  cln_uop_t         uop;
  cln_out_t         res;
  logic             issue;
  logic             accept;
  logic [7:0]       cursor_addr;
  logic             long_sel;

  assign in_ready  = !busy_r;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_data_r;

  assign uop   = cln_rom(pc_r);
  assign issue = busy_r && (!out_valid_r || out_ready);

  assign cursor_addr = CURSOR_FLAG |
                       ({1'b0, line_base_r[in_item.line[1:0]]} + {1'b0, in_item.column});

  always_comb begin
    test_mode_nxt = test_mode_r;
    line_base_nxt = line_base_r;
    short_wait_nxt = short_wait_r;
    long_wait_nxt = long_wait_r;
    pulse_nxt = pulse_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_TEST_MODE:   test_mode_nxt = cfg_wdata[0];
        REG_LINE_BASE_0: line_base_nxt[0] = cfg_wdata[6:0];
        REG_LINE_BASE_1: line_base_nxt[1] = cfg_wdata[6:0];
        REG_LINE_BASE_2: line_base_nxt[2] = cfg_wdata[6:0];
        REG_LINE_BASE_3: line_base_nxt[3] = cfg_wdata[6:0];
        REG_SHORT_WAIT:  short_wait_nxt = cfg_wdata;
        REG_LONG_WAIT:   long_wait_nxt = cfg_wdata;
        REG_PULSE:       pulse_nxt = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (uop.wait_sel)
      WAIT_LONG:          long_sel = 1'b1;
      WAIT_LONG_IF_SMALL: long_sel = !rs_r && ((byte_r & SHORT_MASK) == 8'h00);
      default:            long_sel = 1'b0;
    endcase
    res = '0;
    if (uop.err) begin
      res.status = err_r;
      res.last   = 1'b1;
    end else begin
      res.strobe_valid = 1'b1;
      res.reg_select   = uop.rs_from_reg ? rs_r : 1'b0;
      unique case (uop.nib_sel)
        NIB_HI:  res.nibble = byte_r[7:4];
        NIB_LO:  res.nibble = byte_r[3:0];
        default: res.nibble = uop.nib;
      endcase
      res.enable_us = pulse_r;
      res.wait_us   = long_sel ? long_wait_r : short_wait_r;
      res.status    = STAT_OK;
      res.last      = uop.last;
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    byte_nxt      = byte_r;
    rs_nxt        = rs_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (issue) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
      if (uop.last) begin
        busy_nxt = 1'b0;
      end else begin
        pc_nxt = pc_r + PC_W'(1);
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      busy_nxt = 1'b1;
      rs_nxt   = 1'b0;
      byte_nxt = in_item.byte_value;
      err_nxt  = STAT_OK;
      pc_nxt   = ST_BYTE;
      if (test_mode_r) begin
        err_nxt = STAT_TEST;
        pc_nxt  = ST_ERR;
      end else begin
        unique case (in_item.cmd)
          CMD_DATA:  rs_nxt = 1'b1;
          CMD_CMD:   rs_nxt = 1'b0;
          CMD_INIT: begin
            if (in_item.init_mode != 8'h00) begin
              err_nxt = STAT_UNSUP;
              pc_nxt  = ST_ERR;
            end else begin
              pc_nxt = ST_INIT;
            end
          end
          CMD_CLEAR: byte_nxt = BYTE_CLEAR;
          CMD_CURSOR: begin
            if (int'(in_item.line) >= LINE_CNT) begin
              err_nxt = STAT_BAD_LINE;
              pc_nxt  = ST_ERR;
            end else begin
              byte_nxt = cursor_addr;
            end
          end
          default: begin
            err_nxt = STAT_UNSUP;
            pc_nxt  = ST_ERR;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      test_mode_r    <= 1'b0;
      line_base_r[0] <= 7'd0;
      line_base_r[1] <= 7'd64;
      line_base_r[2] <= 7'd20;
      line_base_r[3] <= 7'd84;
      short_wait_r   <= 16'd40;
      long_wait_r    <= 16'd2000;
      pulse_r        <= 8'd1;
      busy_r         <= 1'b0;
      pc_r           <= ST_ERR;
      out_valid_r    <= 1'b0;
    end else begin
      test_mode_r  <= test_mode_nxt;
      line_base_r  <= line_base_nxt;
      short_wait_r <= short_wait_nxt;
      long_wait_r  <= long_wait_nxt;
      pulse_r      <= pulse_nxt;
      busy_r       <= busy_nxt;
      pc_r         <= pc_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    rs_r       <= rs_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

FILE: design/cln_checker.sv
// Port-level checker for the character LCD nibble sequencer, bound to the top level.
`default_nettype none
module cln_checker import cln_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire cln_out_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.strobe_valid |-> out_item.last && out_item.status != STAT_OK)
    else $error("error item without last or error code");

  a_strobe_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.strobe_valid |-> out_item.status == STAT_OK)
    else $error("strobe item carries an error code");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new item taken before the current one finished");

endmodule

bind char_lcd_nibble_sequencer cln_checker u_cln_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire
